// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file sfx_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/sfx_pkg.sv =====
package sfx_pkg;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] reply_payload;
    } item_t;

    typedef struct packed {
        logic [7:0]         tx_byte;
        logic               frame_done;
        logic               frame_good;
        logic [7:0]         rx_command;
        logic signed [31:0] rx_data;
    } result_t;

    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] tail_byte;
        logic [7:0] ack_command;
    } cfg_t;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK  = 2'd2;

    // byte slots within a frame
    localparam logic [2:0] POS_HEAD = 3'd0;
    localparam logic [2:0] POS_CMD  = 3'd1;
    localparam logic [2:0] POS_D0   = 3'd2;
    localparam logic [2:0] POS_D1   = 3'd3;
    localparam logic [2:0] POS_D2   = 3'd4;
    localparam logic [2:0] POS_D3   = 3'd5;
    localparam logic [2:0] POS_CHK  = 3'd6;
    localparam logic [2:0] POS_TAIL = 3'd7;

endpackage

// ===== src/sfx_core.sv =====
module sfx_core
    import sfx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    logic [2:0]  pos_reg;
    logic [7:0]  check_reg;
    logic [7:0]  command_reg;
    logic [31:0] data_reg;
    logic        head_ok_reg;
    logic [31:0] reply_reg;

    logic [7:0]  reply_xor;
    logic        good;

    assign reply_xor = cfg.ack_command ^ reply_reg[31:24] ^ reply_reg[23:16]
                     ^ reply_reg[15:8] ^ reply_reg[7:0];

    assign good = head_ok_reg && (item.rx_byte == cfg.tail_byte) && (check_reg == 8'h00);

    always_comb
    begin
        res = '0;
        case (pos_reg)
            POS_HEAD: res.tx_byte = cfg.head_byte;
            POS_CMD:  res.tx_byte = cfg.ack_command;
            POS_D0:   res.tx_byte = reply_reg[31:24];
            POS_D1:   res.tx_byte = reply_reg[23:16];
            POS_D2:   res.tx_byte = reply_reg[15:8];
            POS_D3:   res.tx_byte = reply_reg[7:0];
            POS_CHK:  res.tx_byte = reply_xor;
            default:  res.tx_byte = cfg.tail_byte;
        endcase
        if (pos_reg == POS_TAIL)
        begin
            res.frame_done = 1'b1;
            res.frame_good = good;
            res.rx_command = command_reg;
            res.rx_data    = data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_HEAD;
            check_reg   <= '0;
            command_reg <= '0;
            data_reg    <= '0;
            head_ok_reg <= 1'b0;
            reply_reg   <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_reg + 3'd1;
            case (pos_reg) inside
                POS_HEAD:
                begin
                    head_ok_reg <= (item.rx_byte == cfg.head_byte);
                    check_reg   <= '0;
                end
                POS_CMD:
                begin
                    command_reg <= item.rx_byte;
                    check_reg   <= item.rx_byte;
                end
                POS_D0, POS_D1, POS_D2, POS_D3:
                begin
                    data_reg  <= {data_reg[23:0], item.rx_byte};
                    check_reg <= check_reg ^ item.rx_byte;
                end
                POS_CHK:
                begin
                    check_reg <= check_reg ^ item.rx_byte;
                end
                default:
                begin
                    // bad frame sends a zero word next time
                    reply_reg <= good ? item.reply_payload : 32'd0;
                end
            endcase
        end
    end

endmodule

// ===== src/spi_frame_exchange_xor.sv =====
// Slave side of an eight-byte full-duplex frame exchange with XOR checksum.
// item channel: one beat per SPI byte slot, carrying the received byte and
// the word to reply with next if the current frame turns out good.
// result channel: one beat per item, carrying the byte to send in that slot;
// on the eighth slot it also reports frame_done, frame_good, the received
// command and the signed data word.
// A result is valid in the cycle after its item is accepted; throughput is
// one item per cycle while result_ready is high (single result register).
// When the result receiver stalls, the result register holds and item_ready
// drops until the result beat is taken (or is taken in the same cycle).
// Config writes (cfg_we, cfg_index, cfg_data) are registered in cfg_reg;
// index 0 head byte, 1 tail byte, 2 ack command, others are ignored.
// Reset clears the config registers, the slot counter (next byte is a head)
// and the reply word, and empties the result register.
module spi_frame_exchange_xor
    import sfx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t res_next;
    logic    accept;

    assign item_ready = !out_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEAD: cfg_reg.head_byte   <= cfg_data;
                CFG_TAIL: cfg_reg.tail_byte   <= cfg_data;
                CFG_ACK:  cfg_reg.ack_command <= cfg_data;
                default:  ;
            endcase
        end
    end

    sfx_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg_reg),
        .res    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= res_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== src/sfx_checker.sv =====
`include "assert_macros.svh"

module sfx_checker
    import sfx_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    logic result_stalled;
    logic report_zero;

    assign result_stalled = result_valid && !result_ready;
    assign report_zero    = !result.frame_good && (result.rx_command == 8'd0)
                          && (result.rx_data == 32'sd0);

    // a held result beat keeps its payload
    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_stalled, result_valid && $stable(result))

    // an empty result register never back-pressures the input
    `ASSERT_SAME(a_ready_when_empty, clk, rst_n, !result_valid, item_ready)

    // every accepted beat shows up in the next cycle
    `ASSERT_NEXT(a_one_cycle, clk, rst_n, item_valid && item_ready, result_valid)

    // frame report fields stay zero outside the closing slot
    `ASSERT_SAME(a_quiet_midframe, clk, rst_n, result_valid && !result.frame_done, report_zero)

endmodule

bind spi_frame_exchange_xor sfx_checker u_sfx_checker (.*);
